// File: hw/rtl/hdlf_pkg.sv
// Shared types, character codes and helper functions of the hex dump line formatter.
package hdlf_pkg;

    // Input word: one data byte or an end-of-data marker.
    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
    } t_in_word;

    // Output word: one character of dump text.
    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } t_out_word;

    // Input function codes.
    localparam logic FUNC_DATA  = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    // Character codes.
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_COLON   = 8'h3a;
    localparam logic [7:0] CH_DOT     = 8'h2e;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OFS,
        ST_HEX,
        ST_PAD,
        ST_SEP,
        ST_TXT_RD,
        ST_TXT_WR,
        ST_NL
    } t_state;

    // Lowercase hex digit of a nibble.
    function automatic logic [7:0] f_hex(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'h0, nib};
        if (nib < 4'd10) begin
            f_hex = CH_ZERO + wide;
        end else begin
            f_hex = CH_LOWER_A + wide - 8'd10;
        end
    endfunction

    // Character shown in the text column for a raw byte.
    function automatic logic [7:0] f_shown(input logic [7:0] b);
        if (b == CH_NEWLINE || b == CH_TAB || b == CH_NUL) begin
            f_shown = CH_DOT;
        end else begin
            f_shown = b;
        end
    endfunction

endpackage

// File: hw/rtl/hex_dump_line_formatter.sv
// Top level of the hex dump line formatter: sequencer, line memory and output register.
//
// The block turns a stream of bytes into hex dump text, one ASCII character
// per output word. Each line opens with the stream offset as eight lowercase
// hex digits and ": ", each byte adds two hex digits (and a space after every
// odd byte position), and a full line ends with a space, the line's bytes as
// text (newline, tab and zero shown as '.') and a newline. An end-of-data word
// pads a partial line with three spaces per missing byte, adds a space and the
// text, and rewinds the offset to start_offset; with an empty line it emits
// nothing. Characters leave at most one per clock while the consumer takes them.
// A data byte is taken in the idle state, and the offset comes first at the
// start of a line; every text byte of a full line is fetched from the
// synchronous line memory in a read state before it is placed. A new input
// word is taken once every character of the previous one has been placed in
// the output register; the last character may still be waiting there. The
// start_offset register may be written only while the block is idle, and the
// write also loads the running offset.
module hex_dump_line_formatter #(
    parameter int BYTES_PER_LINE = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write channel: start_offset.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [31:0]          i_cfg_data,
    // Input channel.
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  hdlf_pkg::t_in_word   i_in_word,
    // Output channel.
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output hdlf_pkg::t_out_word  o_out_word
);

    // Fill count holds 0..BYTES_PER_LINE; the memory index holds 0..BYTES_PER_LINE-1.
    localparam int FW      = $clog2(BYTES_PER_LINE + 1);
    localparam int IW      = $clog2(BYTES_PER_LINE);
    localparam int PAD_MAX = 3 * (BYTES_PER_LINE - 1);
    localparam int CW      = ($clog2(PAD_MAX + 1) > 4) ? $clog2(PAD_MAX + 1) : 4;
    localparam int OFS_END = 9;

    hdlf_pkg::t_state r_state, n_state;

    logic [31:0]   r_start, n_start;
    logic [31:0]   r_pos, n_pos;
    logic [FW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [IW-1:0] r_idx, n_idx;
    logic [7:0]    r_byte, n_byte;
    logic          r_flush, n_flush;

    logic                 r_out_valid, n_out_valid;
    hdlf_pkg::t_out_word  r_out, n_out;

    // Line memory: written when a data byte is taken, read by the text phase.
    logic [7:0] r_mem [BYTES_PER_LINE];
    logic [7:0] r_rd;

    logic       w_accept;
    logic       w_slot;
    logic       w_emit;
    logic [7:0] w_char;
    logic       w_last;
    logic [3:0] w_nib;
    logic       w_space;
    logic       w_full;
    logic       w_hex_end;
    logic       w_idx_last;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == hdlf_pkg::ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    // The output register can take a character when empty or being drained.
    assign w_slot      = !r_out_valid || i_out_ready;

    assign w_nib      = r_pos[(5'd28 - {r_cnt[2:0], 2'b00}) +: 4];
    assign w_space    = r_fill[0];
    assign w_full     = (r_fill == FW'(BYTES_PER_LINE - 1));
    assign w_hex_end  = w_space ? (r_cnt == CW'(2)) : (r_cnt == CW'(1));
    assign w_idx_last = ((FW'(r_idx) + FW'(1)) == r_fill);

    // Next-state logic. Character states advance only when a character is placed.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hdlf_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_in_word.func == hdlf_pkg::FUNC_DATA) begin
                        n_state = (r_fill == '0) ? hdlf_pkg::ST_OFS : hdlf_pkg::ST_HEX;
                    end else if (r_fill != '0) begin
                        n_state = hdlf_pkg::ST_PAD;
                    end
                end
            end
            hdlf_pkg::ST_OFS: begin
                if (w_slot && r_cnt == CW'(OFS_END)) begin
                    n_state = hdlf_pkg::ST_HEX;
                end
            end
            hdlf_pkg::ST_HEX: begin
                if (w_slot && w_hex_end) begin
                    n_state = w_full ? hdlf_pkg::ST_SEP : hdlf_pkg::ST_IDLE;
                end
            end
            hdlf_pkg::ST_PAD: begin
                if (w_slot && r_cnt == CW'(1)) begin
                    n_state = hdlf_pkg::ST_SEP;
                end
            end
            hdlf_pkg::ST_SEP: begin
                if (w_slot) begin
                    n_state = hdlf_pkg::ST_TXT_RD;
                end
            end
            hdlf_pkg::ST_TXT_RD: begin
                n_state = hdlf_pkg::ST_TXT_WR;
            end
            hdlf_pkg::ST_TXT_WR: begin
                if (w_slot) begin
                    if (!w_idx_last) begin
                        n_state = hdlf_pkg::ST_TXT_RD;
                    end else if (r_flush) begin
                        n_state = hdlf_pkg::ST_IDLE;
                    end else begin
                        n_state = hdlf_pkg::ST_NL;
                    end
                end
            end
            hdlf_pkg::ST_NL: begin
                if (w_slot) begin
                    n_state = hdlf_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // Output and datapath logic.
    always_comb begin
        n_start = r_start;
        n_pos   = r_pos;
        n_fill  = r_fill;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_byte  = r_byte;
        n_flush = r_flush;
        w_emit  = 1'b0;
        w_char  = hdlf_pkg::CH_SPACE;
        w_last  = 1'b0;

        if (i_cfg_valid) begin
            n_start = i_cfg_data;
            n_pos   = i_cfg_data;
        end

        unique case (r_state)
            hdlf_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_byte = i_in_word.data_byte;
                    n_cnt  = '0;
                    n_idx  = '0;
                    if (i_in_word.func == hdlf_pkg::FUNC_DATA) begin
                        n_flush = 1'b0;
                    end else begin
                        n_flush = 1'b1;
                        n_cnt   = CW'(3 * (BYTES_PER_LINE - int'(r_fill)));
                        if (r_fill == '0) begin
                            // Empty line: nothing to print, only the rewind.
                            n_pos = r_start;
                        end
                    end
                end
            end
            hdlf_pkg::ST_OFS: begin
                w_emit = 1'b1;
                if (r_cnt < CW'(8)) begin
                    w_char = hdlf_pkg::f_hex(w_nib);
                end else if (r_cnt == CW'(8)) begin
                    w_char = hdlf_pkg::CH_COLON;
                end else begin
                    w_char = hdlf_pkg::CH_SPACE;
                end
                if (w_slot) begin
                    n_cnt = (r_cnt == CW'(OFS_END)) ? '0 : r_cnt + CW'(1);
                end
            end
            hdlf_pkg::ST_HEX: begin
                w_emit = 1'b1;
                if (r_cnt == '0) begin
                    w_char = hdlf_pkg::f_hex(r_byte[7:4]);
                end else if (r_cnt == CW'(1)) begin
                    w_char = hdlf_pkg::f_hex(r_byte[3:0]);
                end else begin
                    w_char = hdlf_pkg::CH_SPACE;
                end
                w_last = w_hex_end && !w_full;
                if (w_slot) begin
                    n_cnt = r_cnt + CW'(1);
                    if (w_hex_end) begin
                        n_fill = r_fill + FW'(1);
                        n_pos  = r_pos + 32'd1;
                        n_idx  = '0;
                    end
                end
            end
            hdlf_pkg::ST_PAD: begin
                w_emit = 1'b1;
                if (w_slot) begin
                    n_cnt = r_cnt - CW'(1);
                end
            end
            hdlf_pkg::ST_SEP: begin
                w_emit = 1'b1;
            end
            hdlf_pkg::ST_TXT_RD: begin
                // Memory read of entry r_idx is in flight.
            end
            hdlf_pkg::ST_TXT_WR: begin
                w_emit = 1'b1;
                w_char = hdlf_pkg::f_shown(r_rd);
                w_last = w_idx_last && r_flush;
                if (w_slot) begin
                    if (!w_idx_last) begin
                        n_idx = r_idx + IW'(1);
                    end else if (r_flush) begin
                        n_fill = '0;
                        n_pos  = r_start;
                    end
                end
            end
            hdlf_pkg::ST_NL: begin
                w_emit = 1'b1;
                w_char = hdlf_pkg::CH_NEWLINE;
                w_last = 1'b1;
                if (w_slot) begin
                    n_fill = '0;
                end
            end
        endcase

        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_slot) begin
            n_out_valid     = w_emit;
            n_out.out_char  = w_char;
            n_out.last      = w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hdlf_pkg::ST_IDLE;
            r_start     <= '0;
            r_pos       <= '0;
            r_fill      <= '0;
            r_cnt       <= '0;
            r_flush     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_start     <= n_start;
            r_pos       <= n_pos;
            r_fill      <= n_fill;
            r_cnt       <= n_cnt;
            r_flush     <= n_flush;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_byte <= n_byte;
        r_out  <= n_out;
    end

    // The byte lands at the fill position before the text phase reads it.
    always_ff @(posedge i_clk) begin
        if (w_accept && i_in_word.func == hdlf_pkg::FUNC_DATA) begin
            r_mem[r_fill[IW-1:0]] <= i_in_word.data_byte;
        end
        r_rd <= r_mem[r_idx];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

// File: hw/rtl/hdlf_checker.sv
// Port-level assertions for the hex dump line formatter and their bind.
module hdlf_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input hdlf_pkg::t_in_word   i_in_word,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input hdlf_pkg::t_out_word  o_out_word
);

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed while stalled");

    // No new input word while a word that is not the last one waits.
    a_no_accept_mid_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.last |-> !o_in_ready)
        else $error("input ready while an item is still being printed");

    // A data byte always produces characters, so the block is busy right after it.
    a_busy_after_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_word.func == hdlf_pkg::FUNC_DATA |=> !o_in_ready)
        else $error("input ready directly after a data byte");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind hex_dump_line_formatter hdlf_checker u_hdlf_checker (.*);
